// ===== hw/rtl/mac_pkg.sv =====
// Shared types and constants of the matroid axiom checker.
package mac_pkg;

  localparam int REQ_W  = 2;
  localparam int MASK_W = 10;
  localparam int SIZE_W = 4;
  localparam int GS_W   = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  localparam logic REG_GROUND_SIZE = 1'b0;
  localparam logic [GS_W-1:0] GROUND_SIZE_RESET = 4'd10;

  typedef struct packed {
    logic              member;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              accept;
    logic [REQ_W-1:0]  req_type;
    logic [MASK_W-1:0] set_mask;
    logic [SIZE_W-1:0] set_size;
  } req_t;

  typedef struct packed {
    logic fire;
    logic verdict;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_WAIT,
    ST_B_RD,
    ST_B_WAIT,
    ST_K_SCAN,
    ST_K_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/mac_req_if.sv =====
// Request channel: request type, set mask and stated size.
interface mac_req_if;
  logic                       valid;
  logic                       ready;
  logic [mac_pkg::REQ_W-1:0]  req_type;
  logic [mac_pkg::MASK_W-1:0] set_mask;
  logic [mac_pkg::SIZE_W-1:0] set_size;

  modport source (output valid, output req_type, output set_mask, output set_size,
                  input ready);
  modport sink (input valid, input req_type, input set_mask, input set_size,
                output ready);
endinterface

// ===== hw/rtl/mac_res_if.sv =====
// Result channel: one verdict per check request.
interface mac_res_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

// ===== hw/rtl/matroid_axiom_checker_core.sv =====
// Matroid axiom checker: top level with APB config, sequencer, store and result register.
// Load and unknown requests are handled in the idle state; a clear starts the clearing pass.
// A check reads every subset A of the active ground in turn and, for each stored A,
// every subset B, with a scan of the candidate elements of A for each exchange pair.
// One request is in work at a time; the store has a single read port.
// Reset and clear run a clearing pass over all 2^GROUND_MAX entries with ready low.
module matroid_axiom_checker_core #(
  parameter int GROUND_MAX = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mac_pkg::APB_AW-1:0] paddr,
  input  logic [mac_pkg::APB_DW-1:0] pwdata,
  output logic [mac_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  mac_req_if.sink                    req,
  mac_res_if.source                  res
);

  logic [mac_pkg::GS_W-1:0] ground_size;
  mac_pkg::req_t            req_bus;
  mac_pkg::result_t         result;
  mac_pkg::entry_t          wdata;
  mac_pkg::entry_t          rdata;
  logic                     idle;
  logic                     res_free;
  logic                     we;
  logic [GROUND_MAX-1:0]    waddr;
  logic [GROUND_MAX-1:0]    raddr;
  logic                     res_valid;
  logic                     res_verdict;

  mac_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ground_size (ground_size)
  );

  // accept requests whenever the sequencer is idle; a pending verdict does not block
  assign req.ready        = idle;
  assign req_bus.accept   = req.valid && idle;
  assign req_bus.req_type = req.req_type;
  assign req_bus.set_mask = req.set_mask;
  assign req_bus.set_size = req.set_size;

  // the result slot frees when empty or being taken this cycle
  assign res_free = !res_valid || res.ready;

  mac_ctrl #(
    .GROUND_MAX (GROUND_MAX)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .ground_size (ground_size),
    .req         (req_bus),
    .res_free    (res_free),
    .idle        (idle),
    .result      (result),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata)
  );

  mac_store #(
    .AW (GROUND_MAX)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hold the verdict until taken; load a new one when the sequencer finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (result.fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.fire) begin
      res_verdict <= result.verdict;
    end
  end

  assign res.valid   = res_valid;
  assign res.verdict = res_verdict;

endmodule

// ===== hw/rtl/mac_store.sv =====
// Family store: one entry per subset mask, membership flag and stated size.
module mac_store #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mac_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output mac_pkg::entry_t rdata
);

  mac_pkg::entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mac_cfg.sv =====
// APB register block holding the ground size.
module mac_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mac_pkg::APB_AW-1:0] paddr,
  input  logic [mac_pkg::APB_DW-1:0] pwdata,
  output logic [mac_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [mac_pkg::GS_W-1:0]   ground_size
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = paddr[mac_pkg::APB_AW-1] == mac_pkg::REG_GROUND_SIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_size <= mac_pkg::GROUND_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      ground_size <= pwdata[mac_pkg::GS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[mac_pkg::GS_W-1:0] = ground_size;
    end
  end

endmodule

// ===== hw/rtl/mac_ctrl.sv =====
// Sequencer: store clearing, loads and the axiom walk over the store.
module mac_ctrl #(
  parameter int GROUND_MAX = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [mac_pkg::GS_W-1:0] ground_size,
  input  mac_pkg::req_t            req,
  input  logic                     res_free,
  output logic                     idle,
  output mac_pkg::result_t         result,
  output logic                     we,
  output logic [GROUND_MAX-1:0]    waddr,
  output mac_pkg::entry_t          wdata,
  output logic [GROUND_MAX-1:0]    raddr,
  input  mac_pkg::entry_t          rdata
);

  localparam int GW = GROUND_MAX;
  localparam int KW = $clog2(GROUND_MAX + 1);

  mac_pkg::state_t state, state_next;

  logic [GW-1:0]             a, a_next;
  logic [GW-1:0]             b, b_next;
  logic [KW-1:0]             k, k_next;
  logic [mac_pkg::SIZE_W-1:0] a_size, a_size_next;
  logic                      outcome, outcome_next;
  logic [GW-1:0]             clr_cnt, clr_next;

  logic [KW-1:0]             n;
  logic [GW-1:0]             last;
  logic [GW-1:0]             x;
  logic [GW+mac_pkg::MASK_W-1:0] mask_ext;
  logic [GW-1:0]             load_addr;
  logic [mac_pkg::SIZE_W-1:0] load_size;
  logic a_last, b_last, clr_last, subset_fail, need_x, cand, k_end;

  // active ground size, capped at the store's ground
  assign n = (int'(ground_size) > GROUND_MAX) ? KW'(GROUND_MAX) : KW'(ground_size);
  assign last = ~({GW{1'b1}} << n);

  assign mask_ext  = {{GW{1'b0}}, req.set_mask};
  assign load_addr = mask_ext[GW-1:0];
  assign load_size = (int'(req.set_size) > GROUND_MAX) ? mac_pkg::SIZE_W'(GROUND_MAX)
                                                        : req.set_size;

  assign a_last   = a == last;
  assign b_last   = b == last;
  assign clr_last = clr_cnt == {GW{1'b1}};
  assign x        = {{(GW-1){1'b0}}, 1'b1} << k;
  assign k_end    = k == n;

  assign subset_fail = ((a | b) == a) && !rdata.member;
  assign need_x      = rdata.member && (a_size > rdata.size);
  assign cand        = !k_end && ((a & x) != '0) && ((b & x) == '0);

  assign idle        = state == mac_pkg::ST_IDLE;
  assign result.fire    = (state == mac_pkg::ST_DONE) && res_free;
  assign result.verdict = outcome;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mac_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    a       <= a_next;
    b       <= b_next;
    k       <= k_next;
    a_size  <= a_size_next;
    outcome <= outcome_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mac_pkg::ST_CLEAR: begin
        if (clr_last) state_next = mac_pkg::ST_IDLE;
      end
      mac_pkg::ST_IDLE: begin
        if (req.accept) begin
          case (req.req_type)
            mac_pkg::REQ_CLEAR: state_next = mac_pkg::ST_CLEAR;
            mac_pkg::REQ_CHECK: state_next = mac_pkg::ST_A_RD;
            default:            state_next = mac_pkg::ST_IDLE;
          endcase
        end
      end
      mac_pkg::ST_A_RD: state_next = mac_pkg::ST_A_WAIT;
      mac_pkg::ST_A_WAIT: begin
        if (rdata.member)    state_next = mac_pkg::ST_B_RD;
        else if (a == '0)    state_next = mac_pkg::ST_DONE;
        else if (a_last)     state_next = mac_pkg::ST_DONE;
        else                 state_next = mac_pkg::ST_A_RD;
      end
      mac_pkg::ST_B_RD: state_next = mac_pkg::ST_B_WAIT;
      mac_pkg::ST_B_WAIT: begin
        if (subset_fail)     state_next = mac_pkg::ST_DONE;
        else if (need_x)     state_next = mac_pkg::ST_K_SCAN;
        else if (!b_last)    state_next = mac_pkg::ST_B_RD;
        else if (!a_last)    state_next = mac_pkg::ST_A_RD;
        else                 state_next = mac_pkg::ST_DONE;
      end
      mac_pkg::ST_K_SCAN: begin
        if (k_end)           state_next = mac_pkg::ST_DONE;
        else if (cand)       state_next = mac_pkg::ST_K_WAIT;
      end
      mac_pkg::ST_K_WAIT: begin
        if (!rdata.member)   state_next = mac_pkg::ST_K_SCAN;
        else if (!b_last)    state_next = mac_pkg::ST_B_RD;
        else if (!a_last)    state_next = mac_pkg::ST_A_RD;
        else                 state_next = mac_pkg::ST_DONE;
      end
      mac_pkg::ST_DONE: begin
        if (res_free) state_next = mac_pkg::ST_IDLE;
      end
      default: state_next = mac_pkg::ST_CLEAR;
    endcase
  end

  // datapath and store controls
  always_comb begin
    a_next       = a;
    b_next       = b;
    k_next       = k;
    a_size_next  = a_size;
    outcome_next = outcome;
    clr_next     = clr_cnt;
    we           = 1'b0;
    waddr        = clr_cnt;
    wdata        = '0;
    raddr        = a;
    case (state)
      mac_pkg::ST_CLEAR: begin
        we       = 1'b1;
        clr_next = clr_cnt + GW'(1);
      end
      mac_pkg::ST_IDLE: begin
        if (req.accept) begin
          case (req.req_type)
            mac_pkg::REQ_CLEAR: clr_next = '0;
            mac_pkg::REQ_LOAD: begin
              we           = 1'b1;
              waddr        = load_addr;
              wdata.member = 1'b1;
              wdata.size   = load_size;
            end
            mac_pkg::REQ_CHECK: a_next = '0;
            default: ;
          endcase
        end
      end
      mac_pkg::ST_A_RD: raddr = a;
      mac_pkg::ST_A_WAIT: begin
        if (rdata.member) begin
          a_size_next = rdata.size;
          b_next      = '0;
        end else if (a == '0) begin
          outcome_next = 1'b0;
        end else if (a_last) begin
          outcome_next = 1'b1;
        end else begin
          a_next = a + GW'(1);
        end
      end
      mac_pkg::ST_B_RD: raddr = b;
      mac_pkg::ST_B_WAIT: begin
        if (subset_fail) begin
          outcome_next = 1'b0;
        end else if (need_x) begin
          k_next = '0;
        end else if (!b_last) begin
          b_next = b + GW'(1);
        end else if (!a_last) begin
          a_next = a + GW'(1);
        end else begin
          outcome_next = 1'b1;
        end
      end
      mac_pkg::ST_K_SCAN: begin
        raddr = b | x;
        if (k_end) begin
          outcome_next = 1'b0;
        end else if (!cand) begin
          k_next = k + KW'(1);
        end
      end
      mac_pkg::ST_K_WAIT: begin
        if (!rdata.member) begin
          k_next = k + KW'(1);
        end else if (!b_last) begin
          b_next = b + GW'(1);
        end else if (!a_last) begin
          a_next = a + GW'(1);
        end else begin
          outcome_next = 1'b1;
        end
      end
      mac_pkg::ST_DONE: ;
      default: ;
    endcase
  end

endmodule
